// ----- sv/rlp_enc_pkg.sv -----
// RLP item encoder: shared types, command codes and header constants.
// No dependencies; imported by every module of the encoder.
package rlp_enc_pkg;

  typedef enum logic [1:0] {
    CMD_STRING  = 2'd0,
    CMD_INTEGER = 2'd1,
    CMD_LIST    = 2'd2
  } cmd_e;

  localparam logic [7:0]  STR_SHORT  = 8'h80;
  localparam logic [7:0]  STR_LONG   = 8'hb7;
  localparam logic [7:0]  LIST_SHORT = 8'hc0;
  localparam logic [7:0]  LIST_LONG  = 8'hf7;
  localparam logic [7:0]  EMPTY_BYTE = 8'h80;
  localparam logic [7:0]  SINGLE_MAX = 8'h7f;
  localparam logic [31:0] SHORT_MAX  = 32'd55;

  // header byte and count of big-endian length bytes behind it
  typedef struct packed {
    logic [7:0] hdr;
    logic [2:0] nl;
  } hdr_t;

  // one unit of output work: optional header, length bytes, optional data byte
  typedef struct packed {
    logic        hdr_valid;
    logic [7:0]  hdr_byte;
    logic [2:0]  nl;
    logic [31:0] len;
    logic        data_valid;
    logic [7:0]  data;
    logic        done;
  } job_t;

  function automatic hdr_t enc_hdr(logic [31:0] len, logic [7:0] short_base,
                                   logic [7:0] long_base);
    hdr_t       h;
    logic [2:0] n;
    n = 3'd0;
    for (int i = 0; i < 4; i++) begin
      if (len[8*i +: 8] != 8'h00) n = 3'(i + 1);
    end
    if (len <= SHORT_MAX) begin
      h.hdr = short_base + len[7:0];
      h.nl  = 3'd0;
    end else begin
      h.hdr = long_base + {5'b0, n};
      h.nl  = n;
    end
    return h;
  endfunction

endpackage

// ----- sv/rlp_enc_front.sv -----
// RLP encoder front: accepts input items, tracks the open item and
// turns each item into at most one output job. Depends on rlp_enc_pkg.
module rlp_enc_front import rlp_enc_pkg::*; #(
  parameter int LENGTH_BYTES = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  cmd_e        cmd_i,
  input  logic [7:0]  data_byte_i,
  input  logic [31:0] item_length_i,
  output logic        push_o,
  output job_t        job_o
);

  localparam int LW = (LENGTH_BYTES >= 4) ? 32 : 8 * LENGTH_BYTES;

  logic [LW-1:0] pos_q, pos_d, held_q, held_d;
  logic          hs_q, hs_d;

  logic [LW-1:0] len_cut, int_h, int_p, int_p1, int_rem;
  logic          is_open, int_last, int_path;
  hdr_t          h_str, h_int, h_list;
  job_t          job;

  assign len_cut  = item_length_i[LW-1:0];
  assign is_open  = (pos_q != '0);
  assign int_h    = is_open ? held_q : len_cut;
  assign int_p    = is_open ? pos_q : '0;
  assign int_p1   = int_p + LW'(1);
  assign int_rem  = int_h - int_p;
  assign int_last = (int_p1 == int_h);
  assign int_path = is_open || (cmd_i == CMD_INTEGER && len_cut != '0);
  assign h_str    = enc_hdr(32'(len_cut), STR_SHORT, STR_LONG);
  assign h_int    = enc_hdr(32'(int_rem), STR_SHORT, STR_LONG);
  assign h_list   = enc_hdr(32'(len_cut), LIST_SHORT, LIST_LONG);

  always_comb begin
    job    = '0;
    pos_d  = pos_q;
    held_d = held_q;
    hs_d   = hs_q;
    if (fire_i) begin
      if (is_open && hs_q) begin
        job.data_valid = 1'b1;
        job.data       = data_byte_i;
        job.done       = (pos_q + LW'(1) == held_q);
        pos_d          = pos_q + LW'(1);
        if (job.done) begin
          pos_d  = '0;
          held_d = '0;
          hs_d   = 1'b0;
        end
      end else if (int_path) begin
        held_d = int_h;
        hs_d   = 1'b0;
        if (data_byte_i == 8'h00) begin
          pos_d = int_p1;
          if (int_last) begin
            job.data_valid = 1'b1;
            job.data       = EMPTY_BYTE;
            job.done       = 1'b1;
            pos_d          = '0;
            held_d         = '0;
          end
        end else if (int_rem == LW'(1) && data_byte_i <= SINGLE_MAX) begin
          job.data_valid = 1'b1;
          job.data       = data_byte_i;
          job.done       = 1'b1;
          pos_d          = '0;
          held_d         = '0;
        end else begin
          job.hdr_valid  = 1'b1;
          job.hdr_byte   = h_int.hdr;
          job.nl         = h_int.nl;
          job.len        = 32'(int_rem);
          job.data_valid = 1'b1;
          job.data       = data_byte_i;
          job.done       = int_last;
          if (int_last) begin
            pos_d  = '0;
            held_d = '0;
          end else begin
            pos_d = int_p1;
            hs_d  = 1'b1;
          end
        end
      end else begin
        case (cmd_i)
          CMD_LIST: begin
            job.hdr_valid = 1'b1;
            job.hdr_byte  = h_list.hdr;
            job.nl        = h_list.nl;
            job.len       = 32'(len_cut);
            job.done      = 1'b1;
          end
          CMD_STRING, CMD_INTEGER: begin
            job.data_valid = 1'b1;
            job.done       = 1'b1;
            if (len_cut == '0) begin
              job.data = EMPTY_BYTE;
            end else if (len_cut == LW'(1) && data_byte_i <= SINGLE_MAX) begin
              job.data = data_byte_i;
            end else begin
              job.hdr_valid = 1'b1;
              job.hdr_byte  = h_str.hdr;
              job.nl        = h_str.nl;
              job.len       = 32'(len_cut);
              job.data      = data_byte_i;
              job.done      = (len_cut == LW'(1));
              if (len_cut != LW'(1)) begin
                pos_d  = LW'(1);
                held_d = len_cut;
                hs_d   = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign job_o  = job;
  assign push_o = fire_i && (job.hdr_valid || job.data_valid);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      held_q <= '0;
      hs_q   <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      held_q <= held_d;
      hs_q   <= hs_d;
    end
  end

endmodule

// ----- sv/rlp_enc_queue.sv -----
// RLP encoder job queue between front and back.
// Small register FIFO of job_t entries; depends on rlp_enc_pkg.
module rlp_enc_queue import rlp_enc_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  output logic ready_o,
  input  logic pop_i,
  output logic head_valid_o,
  output job_t head_job_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign ready_o      = (cnt_q < CW'(DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_job_o   = mem_q[rd_q];
  assign do_push      = push_i && ready_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      if (do_pop)  rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      cnt_q <= cnt_q + CW'(do_push) - CW'(do_pop);
    end
  end

endmodule

// ----- sv/rlp_enc_back.sv -----
// RLP encoder back: expands the head job into output bytes, one per cycle
// while the output is not stalled, into a registered output stage. Depends on rlp_enc_pkg.
module rlp_enc_back import rlp_enc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  job_t       head_job_i,
  output logic       pop_o,
  output logic       m_valid_o,
  input  logic       m_ready_i,
  output logic [7:0] m_byte_o,
  output logic       m_last_o,
  output logic       m_done_o
);

  logic [2:0] step_q, k, total;
  logic [1:0] lb_idx;
  logic       load, emit, is_last;
  logic [7:0] cur_byte;
  logic       valid_q, last_q, done_q;
  logic [7:0] byte_q;

  assign load    = !valid_q || m_ready_i;
  assign emit    = head_valid_i && load;
  assign total   = {2'b0, head_job_i.hdr_valid} + head_job_i.nl
                 + {2'b0, head_job_i.data_valid};
  assign is_last = (step_q == total - 3'd1);
  assign k       = step_q - {2'b0, head_job_i.hdr_valid};
  assign lb_idx  = 2'(head_job_i.nl - 3'd1 - k);
  assign pop_o   = emit && is_last;

  always_comb begin
    if (head_job_i.hdr_valid && step_q == 3'd0) begin
      cur_byte = head_job_i.hdr_byte;
    end else if (head_job_i.hdr_valid && k < head_job_i.nl) begin
      cur_byte = head_job_i.len[8*lb_idx +: 8];
    end else begin
      cur_byte = head_job_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      byte_q <= cur_byte;
      last_q <= is_last;
      done_q <= is_last && head_job_i.done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      step_q  <= '0;
    end else begin
      if (load) valid_q <= emit;
      if (emit) step_q <= is_last ? 3'd0 : step_q + 3'd1;
    end
  end

  assign m_valid_o = valid_q;
  assign m_byte_o  = byte_q;
  assign m_last_o  = last_q;
  assign m_done_o  = done_q;

endmodule

// ----- sv/rlp_item_encoder_unit.sv -----
// RLP item encoder top level: front, job queue and back.
// Depends on rlp_enc_pkg, rlp_enc_front, rlp_enc_queue, rlp_enc_back.
//
//  channel   dir  tdata                          tuser        tlast
//  s_axis    in   [7:0] data_byte,[39:8] length  command      -
//  m_axis    out  [7:0] out_byte                 item_done    last_in_run
//
// One input item is accepted per cycle while the job queue has room.
// Output runs one byte per cycle while m_axis_tready does not stall it; a job gives its
// header byte, nl length bytes and data byte, each where present (up to 6 bytes); the back expander sets the rate.
// An accepted job passes through the job queue and the registered output stage before its first byte appears.
// Reset clears the open-item state, the queue and the output stage.
module rlp_item_encoder_unit import rlp_enc_pkg::*; #(
  parameter int LENGTH_BYTES = 4,
  parameter int QUEUE_DEPTH  = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // [7:0] data_byte, [39:8] item_length
  input  logic [1:0]  s_axis_tuser,  // [1:0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [7:0] out_byte
  output logic        m_axis_tuser,  // [0] item_done
  output logic        m_axis_tlast
);

  logic push, q_ready, pop, head_valid, fire;
  job_t push_job, head_job;

  assign s_axis_tready = q_ready;
  assign fire          = s_axis_tvalid && q_ready;

  rlp_enc_front #(.LENGTH_BYTES(LENGTH_BYTES)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .cmd_i        (cmd_e'(s_axis_tuser)),
    .data_byte_i  (s_axis_tdata[7:0]),
    .item_length_i(s_axis_tdata[39:8]),
    .push_o       (push),
    .job_o        (push_job)
  );

  rlp_enc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_job_i  (push_job),
    .ready_o     (q_ready),
    .pop_i       (pop),
    .head_valid_o(head_valid),
    .head_job_o  (head_job)
  );

  rlp_enc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_job_i  (head_job),
    .pop_o       (pop),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_byte_o    (m_axis_tdata),
    .m_last_o    (m_axis_tlast),
    .m_done_o    (m_axis_tuser)
  );

endmodule

// ----- sv/rlp_enc_checker.sv -----
// RLP encoder port checker and its bind to rlp_item_encoder_unit.
// Sees the top-level ports only.
module rlp_enc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output item changed while stalled");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("item end not on last byte of its run");

  a_reset_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind rlp_item_encoder_unit rlp_enc_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);

// ----- sim/rlp_item_encoder_unit_tb.sv -----
`timescale 1ns / 1ps
// Testbench for rlp_item_encoder_unit: streams RLP string, integer and list-header items
// and checks every encoded output byte against an untimed encoder model.
// Depends on rlp_enc_pkg and rlp_item_encoder_unit.
module rlp_item_encoder_unit_tb;
  import rlp_enc_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       item_done;
    logic       last_in_run;
  } enc_byte_t;

  class rlp_encode_scoreboard;
    logic [31:0] pos;
    logic [31:0] len_held;
    logic        hdr_out;
    enc_byte_t   run_q[$];
    enc_byte_t   encoded_q[$];
    int          errors;
    int          n_bytes;

    function new();
      pos      = '0;
      len_held = '0;
      hdr_out  = 1'b0;
      errors   = 0;
      n_bytes  = 0;
    endfunction

    function void emit(logic [7:0] b, logic done);
      enc_byte_t e;
      e.out_byte    = b;
      e.item_done   = done;
      e.last_in_run = 1'b0;
      run_q = {run_q, e};
    endfunction

    function void emit_header(logic [31:0] len, logic [7:0] short_base,
                              logic [7:0] long_base, logic done);
      logic [31:0] t;
      int          nl;
      if (len <= SHORT_MAX) begin
        emit(short_base + len[7:0], done);
      end else begin
        nl = 0;
        t  = len;
        while (t != 0) begin
          nl++;
          t = t >> 8;
        end
        emit(long_base + 8'(nl), 1'b0);
        for (int i = nl - 1; i >= 0; i--) emit(len[8*i +: 8], done && (i == 0));
      end
    endfunction

    function void close_item();
      pos      = '0;
      len_held = '0;
      hdr_out  = 1'b0;
    endfunction

    // integer byte before its header is out: leading zeros are dropped
    function void integer_byte(logic [7:0] b);
      logic [31:0] remaining;
      remaining = len_held - pos;
      pos++;
      if (b == 8'h00) begin
        if (pos == len_held) begin
          emit(EMPTY_BYTE, 1'b1);
          close_item();
        end
      end else if (remaining == 1 && b <= SINGLE_MAX) begin
        emit(b, 1'b1);
        close_item();
      end else begin
        emit_header(remaining, STR_SHORT, STR_LONG, 1'b0);
        hdr_out = 1'b1;
        if (pos == len_held) begin
          emit(b, 1'b1);
          close_item();
        end else begin
          emit(b, 1'b0);
        end
      end
    endfunction

    function void accept_item(logic [1:0] cmd, logic [7:0] b, logic [31:0] len);
      run_q.delete();
      if (pos != 0) begin
        if (hdr_out) begin
          pos++;
          if (pos == len_held) begin
            emit(b, 1'b1);
            close_item();
          end else begin
            emit(b, 1'b0);
          end
        end else begin
          integer_byte(b);
        end
      end else if (cmd == CMD_LIST) begin
        emit_header(len, LIST_SHORT, LIST_LONG, 1'b1);
      end else if (cmd == CMD_STRING || cmd == CMD_INTEGER) begin
        if (len == 0) begin
          emit(EMPTY_BYTE, 1'b1);
        end else if (cmd == CMD_INTEGER) begin
          len_held = len;
          hdr_out  = 1'b0;
          integer_byte(b);
        end else if (len == 1 && b <= SINGLE_MAX) begin
          emit(b, 1'b1);
        end else begin
          emit_header(len, STR_SHORT, STR_LONG, 1'b0);
          if (len == 1) begin
            emit(b, 1'b1);
          end else begin
            emit(b, 1'b0);
            pos      = 1;
            len_held = len;
            hdr_out  = 1'b1;
          end
        end
      end
      if (run_q.size() > 0) begin
        run_q[run_q.size() - 1].last_in_run = 1'b1;
      end
      encoded_q = {encoded_q, run_q};
    endfunction

    function void check_byte(logic [7:0] b, logic done, logic last);
      enc_byte_t want;
      n_bytes++;
      if (encoded_q.size() == 0) begin
        $display("%0t: unexpected byte %h (item_done %b, last %b), nothing pending",
                 $time, b, done, last);
        errors++;
      end else begin
        want = encoded_q.pop_front();
        if (want.out_byte !== b) begin
          $display("%0t: out_byte expected %h got %h", $time, want.out_byte, b);
          errors++;
        end
        if (want.item_done !== done) begin
          $display("%0t: item_done expected %b got %b", $time, want.item_done, done);
          errors++;
        end
        if (want.last_in_run !== last) begin
          $display("%0t: last_in_run expected %b got %b", $time, want.last_in_run, last);
          errors++;
        end
      end
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        rx_hold       = 1'b0;
  int          tx_idle_pct   = 0;
  int          rx_stall_pct  = 0;
  int          item_count    = 0;

  rlp_encode_scoreboard board;

  rlp_item_encoder_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      board.check_byte(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  task automatic send_item(input logic [1:0] cmd, input logic [7:0] b,
                           input logic [31:0] len);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {len, b};
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.accept_item(cmd, b, len);
  endtask

  // bytes after the first carry junk command and length fields
  task automatic send_tail_byte(input logic [7:0] b);
    send_item(2'($urandom_range(3)), b, $urandom());
  endtask

  task automatic send_list(input logic [31:0] len);
    send_item(CMD_LIST, 8'($urandom_range(255)), len);
    item_count++;
  endtask

  task automatic send_string(input int len);
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (len == 1 && $urandom_range(1) == 1) b = 8'($urandom_range(127));
    send_item(CMD_STRING, b, len);
    for (int i = 1; i < len; i++) send_tail_byte(8'($urandom_range(255)));
    item_count += (len == 0) ? 1 : len;
  endtask

  task automatic send_integer(input int len, input int zeros);
    logic [7:0] b;
    if (len == 0) begin
      send_item(CMD_INTEGER, 8'($urandom_range(255)), 32'd0);
      item_count++;
    end else begin
      for (int i = 0; i < len; i++) begin
        if (i < zeros || $urandom_range(7) == 0) b = 8'h00;
        else b = 8'($urandom_range(1, 255));
        if (i == 0) send_item(CMD_INTEGER, b, len);
        else send_tail_byte(b);
      end
      item_count += len;
    end
  endtask

  task automatic random_items(input int n);
    int stop_at;
    int kind;
    int sel;
    int len;
    stop_at = item_count + n;
    while (item_count < stop_at) begin
      kind = $urandom_range(99);
      sel  = $urandom_range(19);
      if (kind < 20) begin
        if (sel < 10) len = $urandom_range(55);
        else if (sel < 15) len = $urandom_range(56, 300);
        else len = $urandom();
        send_list(len);
      end else if (kind < 55) begin
        if (sel < 2) len = 0;
        else if (sel < 6) len = 1;
        else if (sel < 17) len = $urandom_range(2, 20);
        else len = $urandom_range(50, 62);
        send_string(len);
      end else if (kind < 92) begin
        if (sel < 2) len = 0;
        else if (sel < 12) len = $urandom_range(1, 8);
        else if (sel < 17) len = $urandom_range(9, 20);
        else len = $urandom_range(54, 62);
        send_integer(len, $urandom_range(0, len));
      end else begin
        // ignored while no item is open
        send_item(CMD_UNUSED, 8'($urandom_range(255)), $urandom());
        item_count++;
      end
    end
  endtask

  initial begin
    board = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners
    send_list(32'd0);
    send_list(32'd55);
    send_list(32'd56);
    send_list(32'h0001_0000);
    send_list(32'hffff_ffff);
    send_item(CMD_UNUSED, 8'hff, 32'hffff_ffff);
    send_item(CMD_STRING, 8'hff, 32'd0);
    send_item(CMD_STRING, 8'h00, 32'd1);
    send_item(CMD_STRING, 8'h7f, 32'd1);
    send_item(CMD_STRING, 8'h80, 32'd1);
    send_item(CMD_STRING, 8'hff, 32'd1);
    send_item(CMD_INTEGER, 8'h55, 32'd0);
    send_item(CMD_INTEGER, 8'h00, 32'd1);
    send_item(CMD_INTEGER, 8'h7f, 32'd1);
    send_item(CMD_INTEGER, 8'h80, 32'd1);
    send_item(CMD_INTEGER, 8'h00, 32'd3);
    send_item(CMD_STRING, 8'h00, 32'd0);
    send_item(CMD_LIST, 8'h05, 32'd9);
    send_item(CMD_INTEGER, 8'h00, 32'd3);
    send_item(CMD_INTEGER, 8'h00, 32'd0);
    send_item(CMD_INTEGER, 8'h00, 32'd0);
    send_item(CMD_INTEGER, 8'h00, 32'd2);
    send_item(CMD_STRING, 8'h81, 32'd7);
    send_item(CMD_STRING, 8'h01, 32'd2);
    send_item(CMD_LIST, 8'hfe, 32'hffff_ffff);
    send_item(CMD_INTEGER, 8'h12, 32'd2);
    send_item(CMD_UNUSED, 8'h34, 32'd0);
    item_count += 22;

    tx_idle_pct = 0;  rx_stall_pct = 0;  random_items(35);
    tx_idle_pct = 50; rx_stall_pct = 0;  random_items(35);
    tx_idle_pct = 0;  rx_stall_pct = 50; random_items(35);
    tx_idle_pct = 8;  rx_stall_pct = 8;  random_items(35);

    // long output hold while a long string streams in at full rate until the job queue fills
    tx_idle_pct = 0;  rx_stall_pct = 0;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (120) @(posedge clk_i);
        rx_hold <= 1'b0;
      end
      begin
        send_string(56 + $urandom_range(8));
        random_items(10);
      end
    join
    s_axis_tvalid <= 1'b0;

    while (board.encoded_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("summary: %0d input items over four idling mixes and a long output hold,",
             item_count);
    $display("summary: %0d encoded bytes compared, %0d mismatches", board.n_bytes,
             board.errors);
    if (board.errors == 0) begin
      $display("rlp_item_encoder_unit_tb: done, clean");
    end else begin
      $display("rlp_item_encoder_unit_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout, %0d bytes still pending", board.encoded_q.size());
    $display("rlp_item_encoder_unit_tb: done, errors");
    $finish;
  end

endmodule

// ----- rlp_item_encoder_unit.f -----
sv/rlp_enc_pkg.sv
sv/rlp_enc_front.sv
sv/rlp_enc_queue.sv
sv/rlp_enc_back.sv
sv/rlp_item_encoder_unit.sv
sv/rlp_enc_checker.sv
sim/rlp_item_encoder_unit_tb.sv
